>>> src/hdms_pkg.sv
// ----------------------------------------------------------------------------
// hdms_pkg
// Shared types, codes and helpers for the hybrid drive mode selector.
// ----------------------------------------------------------------------------
package hdms_pkg;

    localparam int unsigned PERMILLE_W = 10;
    localparam int unsigned SPEED_W    = 12;
    localparam int unsigned BRAKE_W    = 11;
    localparam int unsigned POWER_W    = 16;
    localparam int unsigned PLIMIT_W   = 15;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 15;

    localparam logic [PERMILLE_W-1:0] PERMILLE_MAX = 10'd1000;
    localparam logic signed [BRAKE_W-1:0] BRAKE_MAX = 11'sd1000;
    localparam logic signed [BRAKE_W-1:0] BRAKE_MIN = -11'sd1000;

    // drive mode codes
    typedef enum logic [2:0] {
        MODE_STANDSTILL = 3'd0,
        MODE_ELECTRIC   = 3'd1,
        MODE_ENGINE     = 3'd2,
        MODE_HYBRID     = 3'd3,
        MODE_REGEN      = 3'd4
    } mode_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EV_SPEED_LIMIT     = 3'd0,
        REG_EV_CHARGE_FLOOR    = 3'd1,
        REG_EV_PEDAL_LIMIT     = 3'd2,
        REG_EV_POWER_LIMIT     = 3'd3,
        REG_HYBRID_ENTER_ACCEL = 3'd4,
        REG_HYBRID_EXIT_ACCEL  = 3'd5,
        REG_BRAKE_DEADBAND     = 3'd6
    } cfg_idx_t;

    // thresholds handed from the register file to the mode logic
    typedef struct packed {
        logic [SPEED_W-1:0]    ev_speed_limit;
        logic [PERMILLE_W-1:0] ev_charge_floor;
        logic [PERMILLE_W-1:0] ev_pedal_limit;
        logic [PLIMIT_W-1:0]   ev_power_limit;
        logic [PERMILLE_W-1:0] hybrid_enter_accel;
        logic [PERMILLE_W-1:0] hybrid_exit_accel;
        logic [PERMILLE_W-1:0] brake_deadband;
    } cfg_t;

    // one sensor sample as held in the input register
    typedef struct packed {
        logic [PERMILLE_W-1:0]     accel_level;
        logic signed [BRAKE_W-1:0] brake_level;
        logic [SPEED_W-1:0]        vehicle_speed;
        logic [PERMILLE_W-1:0]     soc_level;
        logic [PERMILLE_W-1:0]     pedal_position;
        logic signed [POWER_W-1:0] power_demand;
    } sample_t;

    // one result
    typedef struct packed {
        mode_t drive_mode;
        logic  generator_enable;
        logic  motor_enable;
        logic  engine_enable;
    } result_t;

    // clamp a per-mille value to full scale
    function automatic logic [PERMILLE_W-1:0] sat_pm(input logic [PERMILLE_W-1:0] v);
        sat_pm = (v > PERMILLE_MAX) ? PERMILLE_MAX : v;
    endfunction

endpackage

>>> src/hdms_cfg_regs.sv
// ----------------------------------------------------------------------------
// hdms_cfg_regs
// Threshold register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module hdms_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic [hdms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hdms_pkg::CFG_DATA_W-1:0]    cfg_data,
    output hdms_pkg::cfg_t                     cfg
);

    hdms_pkg::cfg_t cfg_reg;
    hdms_pkg::cfg_t cfg_next;
    logic [hdms_pkg::PERMILLE_W-1:0] pm_value;

    // per-mille registers are clamped on the way in
    assign pm_value = hdms_pkg::sat_pm(cfg_data[hdms_pkg::PERMILLE_W-1:0]);

    // write decode, unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (hdms_pkg::cfg_idx_t'(cfg_index))
                hdms_pkg::REG_EV_SPEED_LIMIT: begin
                    cfg_next.ev_speed_limit = cfg_data[hdms_pkg::SPEED_W-1:0];
                end
                hdms_pkg::REG_EV_CHARGE_FLOOR:    cfg_next.ev_charge_floor    = pm_value;
                hdms_pkg::REG_EV_PEDAL_LIMIT:     cfg_next.ev_pedal_limit     = pm_value;
                hdms_pkg::REG_EV_POWER_LIMIT: begin
                    cfg_next.ev_power_limit = cfg_data[hdms_pkg::PLIMIT_W-1:0];
                end
                hdms_pkg::REG_HYBRID_ENTER_ACCEL: cfg_next.hybrid_enter_accel = pm_value;
                hdms_pkg::REG_HYBRID_EXIT_ACCEL:  cfg_next.hybrid_exit_accel  = pm_value;
                hdms_pkg::REG_BRAKE_DEADBAND:     cfg_next.brake_deadband     = pm_value;
                default: ;
            endcase
        end
    end

    // register file with reset defaults
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ev_speed_limit     <= 12'd300;
            cfg_reg.ev_charge_floor    <= 10'd370;
            cfg_reg.ev_pedal_limit     <= 10'd400;
            cfg_reg.ev_power_limit     <= 15'd120;
            cfg_reg.hybrid_enter_accel <= 10'd400;
            cfg_reg.hybrid_exit_accel  <= 10'd300;
            cfg_reg.brake_deadband     <= 10'd10;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/hdms_mode_logic.sv
// ----------------------------------------------------------------------------
// hdms_mode_logic
// Next drive mode and enable flags for one sample and the current mode.
// ----------------------------------------------------------------------------
module hdms_mode_logic (
    input  hdms_pkg::cfg_t     cfg,
    input  hdms_pkg::sample_t  sample,
    input  hdms_pkg::mode_t    mode_cur,
    output hdms_pkg::result_t  result
);

    logic [hdms_pkg::PERMILLE_W-1:0]     acc;
    logic [hdms_pkg::PERMILLE_W-1:0]     soc;
    logic [hdms_pkg::PERMILLE_W-1:0]     pedal;
    logic [hdms_pkg::SPEED_W-1:0]        speed;
    logic signed [hdms_pkg::BRAKE_W-1:0] brk;
    logic signed [hdms_pkg::BRAKE_W:0]   brk_x;
    logic signed [hdms_pkg::BRAKE_W:0]   db_x;
    logic signed [hdms_pkg::POWER_W:0]   power_x;
    logic signed [hdms_pkg::POWER_W:0]   plimit_x;
    logic                                ev;
    logic                                to_hybrid;
    logic                                low_soc;
    hdms_pkg::mode_t                     m_brk;
    hdms_pkg::mode_t                     m_new;

    // input clamping
    assign acc   = hdms_pkg::sat_pm(sample.accel_level);
    assign soc   = hdms_pkg::sat_pm(sample.soc_level);
    assign pedal = hdms_pkg::sat_pm(sample.pedal_position);
    assign speed = sample.vehicle_speed;

    always_comb begin
        if (sample.brake_level > hdms_pkg::BRAKE_MAX) begin
            brk = hdms_pkg::BRAKE_MAX;
        end else if (sample.brake_level < hdms_pkg::BRAKE_MIN) begin
            brk = hdms_pkg::BRAKE_MIN;
        end else begin
            brk = sample.brake_level;
        end
    end

    // widen for signed compares
    assign brk_x    = {brk[hdms_pkg::BRAKE_W-1], brk};
    assign db_x     = $signed({2'b00, cfg.brake_deadband});
    assign power_x  = {sample.power_demand[hdms_pkg::POWER_W-1], sample.power_demand};
    assign plimit_x = $signed({2'b00, cfg.ev_power_limit});

    // electric drive permission and hybrid request
    assign low_soc   = soc < cfg.ev_charge_floor;
    assign ev        = (speed <= cfg.ev_speed_limit) && !low_soc &&
                       (pedal <= cfg.ev_pedal_limit) && (power_x <= plimit_x);
    assign to_hybrid = ((acc >= cfg.hybrid_enter_accel) || (speed > cfg.ev_speed_limit)) &&
                       !low_soc;

    // regen has priority, leaving it lands in standstill or electric
    always_comb begin
        m_brk = mode_cur;
        if (brk_x < -db_x) begin
            m_brk = hdms_pkg::MODE_REGEN;
        end else if ((mode_cur == hdms_pkg::MODE_REGEN) && (brk_x > db_x)) begin
            m_brk = (speed == '0) ? hdms_pkg::MODE_STANDSTILL : hdms_pkg::MODE_ELECTRIC;
        end
    end

    // transitions of the resulting state in the same step
    always_comb begin
        m_new = m_brk;
        case (m_brk)
            hdms_pkg::MODE_STANDSTILL: begin
                if ((acc != '0) && ev) begin
                    m_new = hdms_pkg::MODE_ELECTRIC;
                end else if ((acc != '0) && low_soc) begin
                    m_new = hdms_pkg::MODE_ENGINE;
                end
            end
            hdms_pkg::MODE_ELECTRIC: begin
                if ((speed == '0) && (acc == '0)) begin
                    m_new = hdms_pkg::MODE_STANDSTILL;
                end else if (!ev) begin
                    m_new = hdms_pkg::MODE_ENGINE;
                end else if (to_hybrid) begin
                    m_new = hdms_pkg::MODE_HYBRID;
                end
            end
            hdms_pkg::MODE_ENGINE: begin
                if (ev) begin
                    m_new = hdms_pkg::MODE_ELECTRIC;
                end else if (to_hybrid) begin
                    m_new = hdms_pkg::MODE_HYBRID;
                end
            end
            hdms_pkg::MODE_HYBRID: begin
                if (ev && (acc < cfg.hybrid_exit_accel)) begin
                    m_new = hdms_pkg::MODE_ELECTRIC;
                end else if (low_soc) begin
                    m_new = hdms_pkg::MODE_ENGINE;
                end
            end
            default: m_new = m_brk;
        endcase
    end

    // enable flags per mode
    always_comb begin
        result.drive_mode       = m_new;
        result.generator_enable = 1'b0;
        result.motor_enable     = 1'b0;
        result.engine_enable    = 1'b0;
        unique case (m_new)
            hdms_pkg::MODE_STANDSTILL: begin
                result.generator_enable = 1'b1;
                result.motor_enable     = 1'b1;
            end
            hdms_pkg::MODE_ELECTRIC: result.motor_enable = 1'b1;
            hdms_pkg::MODE_ENGINE:   result.engine_enable = 1'b1;
            hdms_pkg::MODE_HYBRID: begin
                result.motor_enable  = 1'b1;
                result.engine_enable = 1'b1;
            end
            hdms_pkg::MODE_REGEN:    result.generator_enable = 1'b1;
            default: ;
        endcase
    end

endmodule

>>> src/hybrid_drive_mode_selector.sv
// Requests pass through the input register and then the result register.
// Throughput: one request per cycle unless m_ready stalls; the mode register update
// sits in the single compare-and-select step between the two registers.
// Reset (aresetn low, synchronous): mode returns to standstill, thresholds take
// their defaults, both pipeline stages are emptied.
// ----------------------------------------------------------------------------
// hybrid_drive_mode_selector
// Five-state drive mode machine with regen priority and electric gating.
// ----------------------------------------------------------------------------
module hybrid_drive_mode_selector (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [hdms_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [hdms_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [hdms_pkg::PERMILLE_W-1:0]        s_accel_level,
    input  logic signed [hdms_pkg::BRAKE_W-1:0]    s_brake_level,
    input  logic [hdms_pkg::SPEED_W-1:0]           s_vehicle_speed,
    input  logic [hdms_pkg::PERMILLE_W-1:0]        s_soc_level,
    input  logic [hdms_pkg::PERMILLE_W-1:0]        s_pedal_position,
    input  logic signed [hdms_pkg::POWER_W-1:0]    s_power_demand,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [2:0]                             m_drive_mode,
    output logic                                   m_generator_enable,
    output logic                                   m_motor_enable,
    output logic                                   m_engine_enable
);

    hdms_pkg::cfg_t    cfg;
    hdms_pkg::sample_t sample_reg;
    logic              in_valid_reg;
    hdms_pkg::mode_t   mode_reg;
    hdms_pkg::result_t result_next;
    hdms_pkg::result_t result_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              s_fire;

    // configuration is always accepted
    assign cfg_ready = 1'b1;

    hdms_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // pipeline handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            sample_reg.accel_level    <= s_accel_level;
            sample_reg.brake_level    <= s_brake_level;
            sample_reg.vehicle_speed  <= s_vehicle_speed;
            sample_reg.soc_level      <= s_soc_level;
            sample_reg.pedal_position <= s_pedal_position;
            sample_reg.power_demand   <= s_power_demand;
        end
    end

    hdms_mode_logic u_mode_logic (
        .cfg      (cfg),
        .sample   (sample_reg),
        .mode_cur (mode_reg),
        .result   (result_next)
    );

    // mode state, updated as each request moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= hdms_pkg::MODE_STANDSTILL;
        end else if (advance) begin
            mode_reg <= result_next.drive_mode;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_drive_mode       = result_reg.drive_mode;
    assign m_generator_enable = result_reg.generator_enable;
    assign m_motor_enable     = result_reg.motor_enable;
    assign m_engine_enable    = result_reg.engine_enable;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hybrid drive mode selector: a shadow mode
// machine predicts every result while directed, corner-config and random
// sensor requests flow under sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
    import hdms_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    localparam int PIPE_LATENCY = 2;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PM_FULL      = 1000;
    localparam int BATCH_SIZE   = 100;

    // index past the end of the register list, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    // sender idle and receiver stall percentages, one entry per phase
    localparam int SEND_IDLE [3] = '{18, 76, 0};
    localparam int RECV_STALL[3] = '{76, 18, 0};

    typedef logic [CFG_DATA_W-1:0] cfg_words_t [7];

    logic                          aclk    = 1'b0;
    logic                          aresetn = 1'b0;

    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data  = '0;

    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [PERMILLE_W-1:0]         s_accel_level    = '0;
    logic signed [BRAKE_W-1:0]     s_brake_level    = '0;
    logic [SPEED_W-1:0]            s_vehicle_speed  = '0;
    logic [PERMILLE_W-1:0]         s_soc_level      = '0;
    logic [PERMILLE_W-1:0]         s_pedal_position = '0;
    logic signed [POWER_W-1:0]     s_power_demand   = '0;

    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [2:0]                    m_drive_mode;
    logic                          m_generator_enable;
    logic                          m_motor_enable;
    logic                          m_engine_enable;

    // shadow of the block: thresholds and the current drive mode
    cfg_t       thresholds = '{ev_speed_limit: 12'd300, ev_charge_floor: 10'd370,
                               ev_pedal_limit: 10'd400, ev_power_limit: 15'd120,
                               hybrid_enter_accel: 10'd400, hybrid_exit_accel: 10'd300,
                               brake_deadband: 10'd10};
    logic [2:0] mode_state = MODE_STANDSTILL;

    result_t    expected_modes[$];
    int         idle_pct    = 0;
    int         stall_pct   = 0;
    int         cycle_count = 0;
    int         error_count = 0;

    hybrid_drive_mode_selector DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_accel_level      (s_accel_level),
        .s_brake_level      (s_brake_level),
        .s_vehicle_speed    (s_vehicle_speed),
        .s_soc_level        (s_soc_level),
        .s_pedal_position   (s_pedal_position),
        .s_power_demand     (s_power_demand),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_drive_mode       (m_drive_mode),
        .m_generator_enable (m_generator_enable),
        .m_motor_enable     (m_motor_enable),
        .m_engine_enable    (m_engine_enable)
    );

    always #CLK_HALF aclk = ~aclk;

    // run watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // result side backpressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic int pm_clip(input int v);
        return (v > PM_FULL) ? PM_FULL : v;
    endfunction

    function automatic int near_val(input int center, input int span, input int lo,
                                    input int hi);
        int v;
        v = center - span + int'($urandom_range(2 * span));
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    // register write as the block applies it
    function automatic void store_threshold(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_EV_SPEED_LIMIT:     thresholds.ev_speed_limit = data[SPEED_W-1:0];
            REG_EV_CHARGE_FLOOR:
                thresholds.ev_charge_floor = PERMILLE_W'(pm_clip(int'(data[PERMILLE_W-1:0])));
            REG_EV_PEDAL_LIMIT:
                thresholds.ev_pedal_limit = PERMILLE_W'(pm_clip(int'(data[PERMILLE_W-1:0])));
            REG_EV_POWER_LIMIT:     thresholds.ev_power_limit = data[PLIMIT_W-1:0];
            REG_HYBRID_ENTER_ACCEL:
                thresholds.hybrid_enter_accel =
                    PERMILLE_W'(pm_clip(int'(data[PERMILLE_W-1:0])));
            REG_HYBRID_EXIT_ACCEL:
                thresholds.hybrid_exit_accel =
                    PERMILLE_W'(pm_clip(int'(data[PERMILLE_W-1:0])));
            REG_BRAKE_DEADBAND:
                thresholds.brake_deadband = PERMILLE_W'(pm_clip(int'(data[PERMILLE_W-1:0])));
            default: ;
        endcase
    endfunction

    // one step of the drive mode machine, advances the shadow mode
    function automatic result_t predict_mode_step(input sample_t smp);
        int         acc, brk, speed, soc, pedal, power, db;
        int         speed_lim, floor_pm;
        logic [2:0] m;
        bit         ev_ok, to_hybrid;
        result_t    r;
        acc       = pm_clip(int'(smp.accel_level));
        brk       = int'($signed(smp.brake_level));
        speed     = int'(smp.vehicle_speed);
        soc       = pm_clip(int'(smp.soc_level));
        pedal     = pm_clip(int'(smp.pedal_position));
        power     = int'($signed(smp.power_demand));
        db        = int'(thresholds.brake_deadband);
        speed_lim = int'(thresholds.ev_speed_limit);
        floor_pm  = int'(thresholds.ev_charge_floor);
        m         = mode_state;
        if (brk > PM_FULL) brk = PM_FULL;
        if (brk < -PM_FULL) brk = -PM_FULL;

        // regen priority, leaving regen lands in standstill or electric
        if (brk < -db) begin
            m = MODE_REGEN;
        end else if (m == MODE_REGEN && brk > db) begin
            m = (speed == 0) ? MODE_STANDSTILL : MODE_ELECTRIC;
        end

        ev_ok = speed <= speed_lim && soc >= floor_pm &&
                pedal <= int'(thresholds.ev_pedal_limit) &&
                power <= int'(thresholds.ev_power_limit);
        to_hybrid = (acc >= int'(thresholds.hybrid_enter_accel) || speed > speed_lim) &&
                    soc >= floor_pm;

        // transition rules of the mode reached so far
        case (m)
            MODE_STANDSTILL: begin
                if (acc > 0 && ev_ok) m = MODE_ELECTRIC;
                else if (acc > 0 && soc < floor_pm) m = MODE_ENGINE;
            end
            MODE_ELECTRIC: begin
                if (speed == 0 && acc == 0) m = MODE_STANDSTILL;
                else if (!ev_ok) m = MODE_ENGINE;
                else if (to_hybrid) m = MODE_HYBRID;
            end
            MODE_ENGINE: begin
                if (ev_ok) m = MODE_ELECTRIC;
                else if (to_hybrid) m = MODE_HYBRID;
            end
            MODE_HYBRID: begin
                if (ev_ok && acc < int'(thresholds.hybrid_exit_accel)) m = MODE_ELECTRIC;
                else if (soc < floor_pm) m = MODE_ENGINE;
            end
            default: ;
        endcase
        mode_state = m;

        r.drive_mode       = mode_t'(m);
        r.generator_enable = (m == MODE_STANDSTILL) || (m == MODE_REGEN);
        r.motor_enable     = (m == MODE_STANDSTILL) || (m == MODE_ELECTRIC) ||
                             (m == MODE_HYBRID);
        r.engine_enable    = (m == MODE_ENGINE) || (m == MODE_HYBRID);
        return r;
    endfunction

    task automatic check_field(input string field, input logic [2:0] want,
                               input logic [2:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    // result checker against the oldest pending expectation
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_modes.size() == 0) begin
                $display("%0t: result with no request pending, expected none got mode %0d",
                         $time, m_drive_mode);
                error_count++;
            end else begin
                want = expected_modes.pop_front();
                check_field("drive_mode", want.drive_mode, m_drive_mode);
                check_field("generator_enable", want.generator_enable, m_generator_enable);
                check_field("motor_enable", want.motor_enable, m_motor_enable);
                check_field("engine_enable", want.engine_enable, m_engine_enable);
            end
        end
    end

    // present one request, predict its result on acceptance
    task automatic send_request(input sample_t smp);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_accel_level    <= smp.accel_level;
        s_brake_level    <= smp.brake_level;
        s_vehicle_speed  <= smp.vehicle_speed;
        s_soc_level      <= smp.soc_level;
        s_pedal_position <= smp.pedal_position;
        s_power_demand   <= smp.power_demand;
        do @(posedge aclk); while (!s_ready);
        expected_modes.push_back(predict_mode_step(smp));
    endtask

    task automatic send_fields(input int acc, input int brk, input int spd, input int soc,
                               input int ped, input int pwr);
        sample_t smp;
        smp.accel_level    = PERMILLE_W'(acc);
        smp.brake_level    = BRAKE_W'(brk);
        smp.vehicle_speed  = SPEED_W'(spd);
        smp.soc_level      = PERMILLE_W'(soc);
        smp.pedal_position = PERMILLE_W'(ped);
        smp.power_demand   = POWER_W'(pwr);
        send_request(smp);
    endtask

    // mostly samples around the current thresholds, some raw noise
    function automatic sample_t rand_sample();
        sample_t smp;
        int      db, pick;
        if ($urandom_range(99) < 20) begin
            smp.accel_level    = PERMILLE_W'($urandom);
            smp.brake_level    = BRAKE_W'($urandom);
            smp.vehicle_speed  = SPEED_W'($urandom);
            smp.soc_level      = PERMILLE_W'($urandom);
            smp.pedal_position = PERMILLE_W'($urandom);
            smp.power_demand   = POWER_W'($urandom);
            return smp;
        end
        db = int'(thresholds.brake_deadband);

        pick = $urandom_range(3);
        case (pick)
            0: smp.accel_level = '0;
            1: smp.accel_level = PERMILLE_W'(near_val(
                   int'(thresholds.hybrid_enter_accel), 15, 0, 1023));
            2: smp.accel_level = PERMILLE_W'(near_val(
                   int'(thresholds.hybrid_exit_accel), 15, 0, 1023));
            default: smp.accel_level = PERMILLE_W'($urandom_range(1023));
        endcase

        // brake: half inside the deadband, edges and firm commands otherwise
        pick = $urandom_range(9);
        if (pick < 5)       smp.brake_level = BRAKE_W'(near_val(0, db, -1024, 1023));
        else if (pick < 7)  smp.brake_level = BRAKE_W'(near_val(-db, 2, -1024, 1023));
        else if (pick == 7) smp.brake_level = BRAKE_W'(near_val(-600, 424, -1024, 1023));
        else if (pick == 8) smp.brake_level = BRAKE_W'(near_val(db, 2, -1024, 1023));
        else                smp.brake_level = BRAKE_W'(near_val(600, 423, -1024, 1023));

        pick = $urandom_range(3);
        if (pick == 0)     smp.vehicle_speed = '0;
        else if (pick < 3) smp.vehicle_speed = SPEED_W'(near_val(
                               int'(thresholds.ev_speed_limit), 8, 0, 4095));
        else               smp.vehicle_speed = SPEED_W'($urandom_range(4095));

        smp.soc_level = ($urandom_range(1) == 0) ?
            PERMILLE_W'(near_val(int'(thresholds.ev_charge_floor), 15, 0, 1023)) :
            PERMILLE_W'($urandom_range(1023));
        smp.pedal_position = ($urandom_range(4) < 3) ?
            PERMILLE_W'(near_val(int'(thresholds.ev_pedal_limit), 20, 0, 1023)) :
            PERMILLE_W'($urandom_range(1023));

        pick = $urandom_range(4);
        if (pick < 2)       smp.power_demand = POWER_W'(near_val(
                                int'(thresholds.ev_power_limit), 20, -32768, 32767));
        else if (pick == 2) smp.power_demand = POWER_W'(near_val(-16384, 16384, -32768, -1));
        else                smp.power_demand = POWER_W'($urandom_range(800));
        return smp;
    endfunction

    task automatic run_batch(input int n);
        repeat (n) send_request(rand_sample());
        s_valid <= 1'b0;
    endtask

    // wait for all results, then let the pipeline settle
    task automatic wait_idle();
        while (expected_modes.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        store_threshold(idx, data);
    endtask

    task automatic apply_config(input cfg_words_t words, input bit poke_spare);
        cfg_idx_t r;
        wait_idle();
        r = r.first();
        do begin
            write_reg(r, words[r]);
            r = r.next();
        end while (r != r.first());
        if (poke_spare) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic cfg_words_t rand_config();
        cfg_words_t words;
        words[REG_EV_SPEED_LIMIT]     = CFG_DATA_W'($urandom_range(1000));
        words[REG_EV_CHARGE_FLOOR]    = CFG_DATA_W'($urandom_range(1000));
        words[REG_EV_PEDAL_LIMIT]     = CFG_DATA_W'($urandom_range(1000));
        words[REG_EV_POWER_LIMIT]     = CFG_DATA_W'($urandom_range(2000));
        words[REG_HYBRID_ENTER_ACCEL] = CFG_DATA_W'($urandom_range(1000));
        words[REG_HYBRID_EXIT_ACCEL]  = CFG_DATA_W'($urandom_range(1000));
        words[REG_BRAKE_DEADBAND]     = CFG_DATA_W'($urandom_range(100));
        // occasional raw words exercise truncation and saturation
        foreach (words[i]) begin
            if ($urandom_range(99) < 15) words[i] = CFG_DATA_W'($urandom);
        end
        return words;
    endfunction

    // every transition at reset thresholds, plus field extremes
    task automatic test_directed();
        idle_pct  = SEND_IDLE[0];
        stall_pct = RECV_STALL[0];
        send_fields(0, 0, 0, 500, 0, 0);                   // standstill holds
        send_fields(100, 0, 100, 800, 100, 50);            // standstill to electric
        send_fields(0, 0, 0, 800, 0, 0);                   // electric to standstill
        send_fields(100, 0, 100, 100, 100, 50);            // low charge to engine
        send_fields(100, 0, 100, 800, 100, 50);            // engine to electric
        send_fields(500, 0, 100, 800, 100, 50);            // electric to hybrid
        send_fields(200, 0, 100, 800, 100, 50);            // hybrid back to electric
        send_fields(100, 0, 100, 800, 100, 500);           // power too high to engine
        send_fields(100, 0, 400, 800, 100, 50);            // engine to hybrid on speed
        send_fields(500, 0, 400, 100, 100, 50);            // hybrid to engine, low charge
        send_fields(0, -500, 100, 800, 100, 50);           // regen entry
        send_fields(0, -10, 100, 800, 100, 50);            // deadband edge, stays regen
        send_fields(0, 10, 100, 800, 100, 50);             // deadband edge, stays regen
        send_fields(0, 11, 0, 800, 0, 0);                  // leave regen at rest
        send_fields(0, -11, 0, 800, 0, 0);                 // just past deadband
        send_fields(100, 500, 100, 800, 100, 50);          // leave regen moving
        send_fields(0, -1024, 4095, 1023, 1023, 32767);    // field maxima, saturated brake
        send_fields(1023, 1023, 4095, 1023, 1023, -32768); // leave regen, then engine
        send_fields(1023, 0, 0, 1023, 0, -32768);          // negative power passes
        send_fields(0, 0, 0, 0, 0, -1);                    // electric to standstill
        send_fields(1000, 0, 4095, 0, 1000, 32767);        // standstill to engine
        send_fields(0, -1000, 0, 0, 0, 0);                 // regen at full brake
        send_fields(0, 1000, 0, 0, 0, 0);                  // back to standstill
        send_fields(300, 0, 300, 370, 400, 120);           // all limits exactly met
        send_fields(400, 0, 300, 370, 400, 120);           // hybrid entry at threshold
        send_fields(300, 0, 300, 370, 400, 121);           // power one over, hybrid holds
        s_valid <= 1'b0;
    endtask

    // all-zero and all-ones register settings
    task automatic test_config_extremes();
        cfg_words_t words;
        idle_pct  = SEND_IDLE[1];
        stall_pct = RECV_STALL[1];
        foreach (words[i]) words[i] = '0;
        apply_config(words, 1'b0);
        run_batch(60);
        foreach (words[i]) words[i] = '1;
        apply_config(words, 1'b1);
        run_batch(60);
    endtask

    // random sweep across the three idling phases
    task automatic test_random_sweep();
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct  = SEND_IDLE[ph];
            stall_pct = RECV_STALL[ph];
            repeat (4) begin
                apply_config(rand_config(), $urandom_range(2) == 0);
                run_batch(BATCH_SIZE);
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_config_extremes();
        test_random_sweep();
        wait_idle();
        if (error_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
